FILE: rtl/soupbintcp_packet_deframer_macros.svh
// ----------------------------------------------------------------------------
// SoupBinTCP deframer assertion macros
// Shared concurrent assertion helpers; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef SOUPBINTCP_PACKET_DEFRAMER_MACROS_SVH
`define SOUPBINTCP_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define SBTPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBTPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sbtpd_pkg.sv
// ----------------------------------------------------------------------------
// sbtpd_pkg
// Shared types and codes for the SoupBinTCP packet deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbtpd_pkg;

  localparam int SEQ_W    = 64;  // sequence counter width, 32..64
  localparam int SEQ_OUT_W = 64; // sequence_number field width

  // result status codes
  localparam logic [2:0] ST_PAYLOAD     = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_END_SESSION = 3'd2;
  localparam logic [2:0] ST_ZERO_LEN    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED   = 3'd4;
  localparam logic [2:0] ST_PARTIAL     = 3'd5;
  localparam logic [2:0] ST_CLEAN_END   = 3'd6;

  // framing phases
  localparam logic [2:0] PH_LEN_HI = 3'd0;
  localparam logic [2:0] PH_LEN_LO = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_ZBODY  = 3'd4;

  // packet types
  localparam logic [7:0] TYPE_END_SESSION = 8'h5A;
  localparam logic [7:0] TYPE_SEQUENCED   = 8'h53;

  typedef struct packed {
    logic [2:0]           status;
    logic [7:0]           payload_byte;
    logic [SEQ_OUT_W-1:0] sequence_number;
    logic                 first_of_message;
    logic                 last_of_message;
  } result_t;

endpackage

FILE: rtl/sbtpd_core.sv
// ----------------------------------------------------------------------------
// sbtpd_core
// Framing state and per-byte decode; one byte per take strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "soupbintcp_packet_deframer_macros.svh"

module sbtpd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              cmd,
  input  logic [7:0]        data_byte,
  output logic              res_vld,
  output sbtpd_pkg::result_t res
);
  import sbtpd_pkg::*;

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [15:0]      left_r, left_nxt;
  logic             seqd_r, seqd_nxt;
  logic             first_r, first_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic             halted_r, halted_nxt;

  logic [2:0]       ph;
  logic [15:0]      len;
  logic [15:0]      left_dec;
  logic [SEQ_W-1:0] seq_inc;

  assign len      = {len_hi_r, data_byte};
  assign left_dec = left_r - 16'd1;
  assign seq_inc  = seq_r + SEQ_W'(1);
  assign ph       = (phase_r > PH_ZBODY) ? PH_LEN_HI : phase_r;

  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    seqd_nxt   = seqd_r;
    first_nxt  = first_r;
    seq_nxt    = seq_r;
    halted_nxt = halted_r;
    res_vld    = 1'b0;
    res        = '0;
    if (take && !halted_r) begin
      if (cmd) begin
        // end of input: always halts
        halted_nxt = 1'b1;
        res_vld    = 1'b1;
        if (ph == PH_LEN_HI) begin
          res.status = ST_CLEAN_END;
        end else if (ph == PH_LEN_LO) begin
          res.status = ST_PARTIAL;
        end else begin
          res.status = ST_TRUNCATED;
        end
      end else begin
        unique case (ph)
          PH_LEN_LO: begin
            if (len == 16'd0) begin
              halted_nxt = 1'b1;
              res_vld    = 1'b1;
              res.status = ST_ZERO_LEN;
            end else begin
              left_nxt  = len - 16'd1;
              phase_nxt = PH_TYPE;
            end
          end
          PH_TYPE: begin
            if (data_byte == TYPE_END_SESSION) begin
              if (left_r == 16'd0) begin
                halted_nxt = 1'b1;
                res_vld    = 1'b1;
                res.status = ST_END_SESSION;
              end else begin
                phase_nxt = PH_ZBODY;
              end
            end else if (data_byte == TYPE_SEQUENCED) begin
              seq_nxt = seq_inc;
              if (left_r == 16'd0) begin
                seqd_nxt            = 1'b0;
                phase_nxt           = PH_LEN_HI;
                res_vld             = 1'b1;
                res.status          = ST_EMPTY;
                res.sequence_number = SEQ_OUT_W'(seq_inc);
              end else begin
                seqd_nxt  = 1'b1;
                first_nxt = 1'b1;
                phase_nxt = PH_BODY;
              end
            end else begin
              seqd_nxt  = 1'b0;
              phase_nxt = (left_r == 16'd0) ? PH_LEN_HI : PH_BODY;
            end
          end
          PH_BODY: begin
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              phase_nxt = PH_LEN_HI;
            end
            if (seqd_r) begin
              first_nxt            = 1'b0;
              res_vld              = 1'b1;
              res.status           = ST_PAYLOAD;
              res.payload_byte     = data_byte;
              res.sequence_number  = SEQ_OUT_W'(seq_r);
              res.first_of_message = first_r;
              res.last_of_message  = (left_dec == 16'd0);
            end
          end
          PH_ZBODY: begin
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              halted_nxt = 1'b1;
              res_vld    = 1'b1;
              res.status = ST_END_SESSION;
            end
          end
          default: begin
            len_hi_nxt = data_byte;
            phase_nxt  = PH_LEN_LO;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN_HI;
      len_hi_r <= '0;
      left_r   <= '0;
      seqd_r   <= 1'b0;
      first_r  <= 1'b0;
      seq_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      seqd_r   <= seqd_nxt;
      first_r  <= first_nxt;
      seq_r    <= seq_nxt;
      halted_r <= halted_nxt;
    end
  end

  `SBTPD_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt released")
  `SBTPD_ASSERT_NOW(a_no_res_halted, halted_r, !res_vld, "result while halted")
  `SBTPD_ASSERT_NOW(a_res_needs_take, res_vld, take, "result without a beat")
  `SBTPD_ASSERT_NOW(a_marks_payload_only,
      res_vld && (res.status != ST_PAYLOAD),
      !res.first_of_message && !res.last_of_message, "marks on non-payload result")

endmodule

FILE: rtl/sbtpd_out_reg.sv
// ----------------------------------------------------------------------------
// sbtpd_out_reg
// Result register on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbtpd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               res_vld,
  input  sbtpd_pkg::result_t res,
  input  logic               out_ready,
  output logic               out_valid,
  output sbtpd_pkg::result_t out_res
);
  import sbtpd_pkg::*;

  logic    vld_r;
  result_t res_r;

  // load only when the slot is empty or draining this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= res_vld;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/soupbintcp_packet_deframer.sv
// ----------------------------------------------------------------------------
// soupbintcp_packet_deframer
// Length-prefixed packet deframer: one stream byte in, at most one result out.
// ----------------------------------------------------------------------------
// Takes one beat per clock, sustained, as long as results are drained. Each
// beat carries one stream byte or an end-of-input mark. A beat waits in the
// input register until the output slot is free or draining, is decoded
// against the framing state, and its result (if any) lands in the output
// register, which drives out_valid. The framing state update includes the
// 64-bit sequence counter increment.
// Sequenced packets emit one result per payload byte, tagged with the packet
// sequence and first/last marks; an empty sequenced packet emits one empty
// result. End session, zero length, truncation, partial prefix and clean end
// each emit one status result and stop the block; after that every beat is
// accepted and dropped. Other packet types are consumed silently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module soupbintcp_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_payload_byte,
  output logic [sbtpd_pkg::SEQ_OUT_W-1:0] out_sequence_number,
  output logic        out_first_of_message,
  output logic        out_last_of_message
);
  import sbtpd_pkg::*;

  // input register
  logic       in_v_r;
  logic       cmd_r;
  logic [7:0] byte_r;

  logic    advance;   // beat in the input register is decoded this cycle
  logic    res_vld;
  result_t res;
  result_t out_res;

  // decode may proceed when the output slot is free or being drained
  assign advance  = in_v_r && (!out_valid || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r  <= in_cmd;
      byte_r <= in_data_byte;
    end
  end

  sbtpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (advance),
    .cmd       (cmd_r),
    .data_byte (byte_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  sbtpd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_vld   (res_vld),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_status           = out_res.status;
  assign out_payload_byte     = out_res.payload_byte;
  assign out_sequence_number  = out_res.sequence_number;
  assign out_first_of_message = out_res.first_of_message;
  assign out_last_of_message  = out_res.last_of_message;

endmodule

FILE: sim/soupbintcp_deframe_checker.sv
// ----------------------------------------------------------------------------
// soupbintcp_deframe_checker
// Watches both beat channels of the deframer, predicts results, compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module soupbintcp_deframe_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [7:0]                      in_data_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [2:0]                      out_status,
  input  logic [7:0]                      out_payload_byte,
  input  logic [sbtpd_pkg::SEQ_OUT_W-1:0] out_sequence_number,
  input  logic                            out_first_of_message,
  input  logic                            out_last_of_message,
  output int                              mismatch_total,
  output int                              results_owed
);
  import sbtpd_pkg::*;

  // framing state, mirrors the block
  logic [2:0]       phase;
  logic [7:0]       length_high;
  logic [15:0]      bytes_left;
  logic             seq_packet;
  logic             first_pending;
  logic [SEQ_W-1:0] seq_count;
  logic             halted;

  result_t owed_results[$];
  int      mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] deframer mismatch: %s", $realtime, what);
  endtask

  task automatic stop_with(input logic [2:0] code);
    result_t r;
    r        = '0;
    r.status = code;
    halted   = 1'b1;
    owed_results.push_back(r);
  endtask

  // One accepted beat through the framing state; queues the result it causes.
  task automatic deframe_beat(input logic end_of_input, input logic [7:0] b);
    logic [2:0]  ph;
    logic [15:0] len;
    logic        first;
    result_t     r;
    r = '0;
    if (!halted) begin
      ph = (phase > PH_ZBODY) ? PH_LEN_HI : phase;
      if (end_of_input) begin
        if (ph == PH_LEN_HI)
          stop_with(ST_CLEAN_END);
        else if (ph == PH_LEN_LO)
          stop_with(ST_PARTIAL);
        else
          stop_with(ST_TRUNCATED);
      end else begin
        case (ph)
          PH_LEN_LO: begin
            len = {length_high, b};
            if (len == 16'd0) begin
              stop_with(ST_ZERO_LEN);
            end else begin
              bytes_left = len - 16'd1;
              phase      = PH_TYPE;
            end
          end
          PH_TYPE: begin
            if (b == TYPE_END_SESSION) begin
              if (bytes_left == 16'd0)
                stop_with(ST_END_SESSION);
              else
                phase = PH_ZBODY;
            end else if (b == TYPE_SEQUENCED) begin
              seq_count = seq_count + 1'b1;
              if (bytes_left == 16'd0) begin
                seq_packet        = 1'b0;
                phase             = PH_LEN_HI;
                r.status          = ST_EMPTY;
                r.sequence_number = SEQ_OUT_W'(seq_count);
                owed_results.push_back(r);
              end else begin
                seq_packet    = 1'b1;
                first_pending = 1'b1;
                phase         = PH_BODY;
              end
            end else begin
              seq_packet = 1'b0;
              phase      = (bytes_left == 16'd0) ? PH_LEN_HI : PH_BODY;
            end
          end
          PH_BODY: begin
            first      = first_pending;
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0)
              phase = PH_LEN_HI;
            if (seq_packet) begin
              first_pending      = 1'b0;
              r.status           = ST_PAYLOAD;
              r.payload_byte     = b;
              r.sequence_number  = SEQ_OUT_W'(seq_count);
              r.first_of_message = first;
              r.last_of_message  = (bytes_left == 16'd0);
              owed_results.push_back(r);
            end
          end
          PH_ZBODY: begin
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0)
              stop_with(ST_END_SESSION);
          end
          default: begin
            length_high = b;
            phase       = PH_LEN_LO;
          end
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      phase         = PH_LEN_HI;
      length_high   = '0;
      bytes_left    = '0;
      seq_packet    = 1'b0;
      first_pending = 1'b0;
      seq_count     = '0;
      halted        = 1'b0;
      owed_results.delete();
    end else begin
      // a result can never come from the beat taken at this same edge
      if (in_valid && in_ready)
        deframe_beat(in_cmd, in_data_byte);
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, out_status %0d", out_status));
        end else begin
          want = owed_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("out_status %0d, want %0d", out_status, want.status));
          if (out_payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %0h, want %0h",
                                      out_payload_byte, want.payload_byte));
          if (out_sequence_number !== want.sequence_number)
            report_mismatch($sformatf("sequence_number %0h, want %0h",
                                      out_sequence_number, want.sequence_number));
          if (out_first_of_message !== want.first_of_message)
            report_mismatch($sformatf("first_of_message %b, want %b",
                                      out_first_of_message, want.first_of_message));
          if (out_last_of_message !== want.last_of_message)
            report_mismatch($sformatf("last_of_message %b, want %b",
                                      out_last_of_message, want.last_of_message));
        end
      end
    end
    results_owed   <= owed_results.size();
    mismatch_total <= mismatches;
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the SoupBinTCP deframer and gives the verdict.
// ----------------------------------------------------------------------------
// Stimulus: a directed run of small packets (first/last marks, one-byte and
// empty sequenced packets, skipped types, type codes inside bodies, byte
// extremes), then a long run of random well-formed packets, mostly sequenced,
// the rest other types as filler. The block stops for good on any terminal
// event and reset comes only once, so each run ends with one terminal event
// picked at random; seeds cover the set. A few beats after the stop check
// that a halted block drops everything. Checking lives in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sbtpd_pkg::*;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int RANDOM_BEATS = 1650;
  localparam int CALM_AFTER   = 1500;  // no idling past this many beats
  localparam int DRAIN_CYCLES = 20;    // input and output registers plus margin

  // Worst case is about 2100 beats, each possibly behind a send gap and a
  // result stall; the limit leaves a wide margin.
  localparam longint LIMIT_NS = 10_000_000;

  // how the run ends; only one of these can happen per reset
  typedef enum int {
    END_CLEAN,
    END_PARTIAL,
    END_ZERO_LEN,
    END_CUT_AT_TYPE,
    END_CUT_IN_BODY,
    END_SESSION_EMPTY,
    END_SESSION_BODY,
    END_SESSION_CUT
  } ending_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_BYTE;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_status;
  logic [7:0]           out_payload_byte;
  logic [SEQ_OUT_W-1:0] out_sequence_number;
  logic                 out_first_of_message;
  logic                 out_last_of_message;

  int mismatch_total;
  int results_owed;

  int beats_sent = 0;
  bit calm = 1'b0;       // set for the tail of the run
  int pressure = 0;      // 0 none, 1 light, 2 heavy idling
  int cycle_count = 0;
  int stall_left = 0;

  soupbintcp_packet_deframer u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_payload_byte     (out_payload_byte),
    .out_sequence_number  (out_sequence_number),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message)
  );

  soupbintcp_deframe_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_payload_byte     (out_payload_byte),
    .out_sequence_number  (out_sequence_number),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message),
    .mismatch_total       (mismatch_total),
    .results_owed         (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // Idling intensity is redrawn at random as the run goes on, so some stretches run with
  // no idling at all and others are choppy.
  function automatic bit idle_now();
    if (calm)
      return 1'b0;
    case (pressure)
      1:       return $urandom_range(0, 15) == 0;
      2:       return $urandom_range(0, 3) == 0;
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0)
      pressure <= calm ? 0 : $urandom_range(0, 2);
  end

  // result side: ready drops in random-length bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idle_now()) begin
      stall_left <= $urandom_range(1, 17);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One beat: optional idle burst, then hold valid until taken.
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    int gap;
    if (idle_now()) begin
      gap      = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // length prefix, type byte, len-1 random body bytes
  task automatic send_packet(input logic [15:0] len, input logic [7:0] kind);
    send_beat(CMD_BYTE, len[15:8]);
    send_beat(CMD_BYTE, len[7:0]);
    send_beat(CMD_BYTE, kind);
    for (int i = 1; i < len; i++)
      send_beat(CMD_BYTE, 8'($urandom));
  endtask

  function automatic logic [7:0] filler_type();
    logic [7:0] t;
    do t = 8'($urandom); while (t == TYPE_END_SESSION);
    return t;
  endfunction

  initial begin
    logic [15:0] len;
    logic [7:0]  kind;
    ending_t     ending;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two-byte body with both byte extremes, first/last on separate beats
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'h03);
    send_beat(CMD_BYTE, TYPE_SEQUENCED);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'hFF);
    // single-byte body: first and last on one beat
    send_packet(16'd2, TYPE_SEQUENCED);
    // empty sequenced packet -> empty-message result
    send_packet(16'd1, TYPE_SEQUENCED);
    // skipped types, empty and with type codes inside the body
    send_packet(16'd1, 8'h41);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'h03);
    send_beat(CMD_BYTE, 8'h55);
    send_beat(CMD_BYTE, TYPE_END_SESSION);
    send_beat(CMD_BYTE, TYPE_SEQUENCED);
    // sequenced body that carries type codes as data
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'h03);
    send_beat(CMD_BYTE, TYPE_SEQUENCED);
    send_beat(CMD_BYTE, TYPE_END_SESSION);
    send_beat(CMD_BYTE, TYPE_SEQUENCED);

    // random well-formed traffic; every so often a length of 200 to 320
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent >= CALM_AFTER)
        calm = 1'b1;
      kind = ($urandom_range(0, 9) < 7) ? TYPE_SEQUENCED : filler_type();
      if ($urandom_range(0, 39) == 0)
        len = 16'($urandom_range(200, 320));
      else
        len = 16'($urandom_range(1, 16));
      send_packet(len, kind);
    end

    // terminal event
    ending = ending_t'($urandom_range(0, 7));
    case (ending)
      END_CLEAN: begin
        send_beat(CMD_END, 8'($urandom));
      end
      END_PARTIAL: begin
        send_beat(CMD_BYTE, 8'($urandom));
        send_beat(CMD_END, 8'($urandom));
      end
      END_ZERO_LEN: begin
        send_beat(CMD_BYTE, 8'h00);
        send_beat(CMD_BYTE, 8'h00);
      end
      END_CUT_AT_TYPE: begin
        send_beat(CMD_BYTE, 8'h00);
        send_beat(CMD_BYTE, 8'($urandom_range(1, 255)));
        send_beat(CMD_END, 8'($urandom));
      end
      END_CUT_IN_BODY: begin
        // huge declared length, body cut short after up to four payload beats
        send_beat(CMD_BYTE, 8'hFF);
        send_beat(CMD_BYTE, 8'($urandom));
        send_beat(CMD_BYTE, TYPE_SEQUENCED);
        repeat ($urandom_range(0, 4)) send_beat(CMD_BYTE, 8'($urandom));
        send_beat(CMD_END, 8'($urandom));
      end
      END_SESSION_EMPTY: begin
        send_packet(16'd1, TYPE_END_SESSION);
      end
      END_SESSION_BODY: begin
        send_packet(16'($urandom_range(2, 6)), TYPE_END_SESSION);
      end
      default: begin
        send_beat(CMD_BYTE, 8'h00);
        send_beat(CMD_BYTE, 8'h05);
        send_beat(CMD_BYTE, TYPE_END_SESSION);
        repeat ($urandom_range(0, 3)) send_beat(CMD_BYTE, 8'($urandom));
        send_beat(CMD_END, 8'($urandom));
      end
    endcase

    // halted: everything from here on must vanish
    send_beat(CMD_END, 8'($urandom));
    repeat (16) send_beat(logic'($urandom_range(0, 3) == 0), 8'($urandom));
    in_valid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0 && results_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
